FILE: sv/assert_macros.svh
// Assertion macros shared by the framebuffer core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define LR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: property violated");

// Condition must never be true outside reset.
`define LR_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: forbidden condition seen");

`else

`define LR_ASSERT(lbl, clk, rst_n, prop)
`define LR_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

FILE: sv/lr2fb_pkg.sv
// Shared types and constants of the 2bpp line raster framebuffer.
package lr2fb_pkg;

    localparam int CANVAS_WIDTH  = 256;
    localparam int CANVAS_HEIGHT = 128;
    localparam int FB_PIXELS     = CANVAS_WIDTH * CANVAS_HEIGHT;
    localparam int FB_BYTES      = (FB_PIXELS + 3) / 4;
    localparam int FB_AW         = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int PIX_W         = FB_AW + 2;

    localparam int COORD_W = 12;
    localparam int DELTA_W = 12;
    localparam int ERR_W   = 15;
    localparam int STEP_W  = 13;
    localparam int GRAY_W  = 2;
    localparam int MODE_W  = 2;

    localparam logic [STEP_W-1:0] MAX_STEPS       = STEP_W'(4096);
    localparam logic [GRAY_W-1:0] OFF_CANVAS_GRAY = 2'h3;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    localparam logic [MODE_W-1:0] MODE_LINE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        OP_LINE,
        OP_READ,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  x0;
        logic signed [COORD_W-1:0]  y0;
        logic signed [COORD_W-1:0]  x1;
        logic signed [COORD_W-1:0]  y1;
        logic        [GRAY_W-1:0]   gray;
        logic        [DELTA_W-1:0]  dx;     // |x1 - x0|
        logic        [DELTA_W-1:0]  dy;     // |y1 - y0|
        logic                       sx_neg;
        logic                       sy_neg;
    } t_cmd;

endpackage

FILE: sv/line_raster_2bpp_framebuffer_core.sv
// Top level of the 2bpp line raster framebuffer core.
//
// A 2-bit-per-pixel framebuffer of CANVAS_WIDTH x CANVAS_HEIGHT pixels
// (256 x 128 by default, four pixels per byte, first pixel in bits 7:6)
// held in one byte-wide RAM of FB_BYTES entries. A transaction is taken
// when start is high and busy is low. Mode 0 draws a Bresenham line with
// both endpoints, skipping off-canvas points; mode 1 reads the pixel at the
// start point (gray 3 off canvas); mode 2 fills the buffer with one gray;
// mode 3 does nothing. Each transaction gives exactly one result, shown for
// a single cycle on o_read_gray/o_steps_taken with o_result_strobe high;
// there is no backpressure, so the receiver must take it in that cycle.
// Timing is set by the single frame RAM port pair: a line handles each
// point as a read, then a merge and write back, once the command has
// passed the front, queue and dispatch; a clear writes one byte per cycle.
// After reset a clearing pass zeroes the RAM while busy stays high.
// A front stage and a two-entry queue let up to three commands be taken
// while the back end is still working; results always come out in order.
module line_raster_2bpp_framebuffer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [lr2fb_pkg::MODE_W-1:0]         i_mode,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_y_start,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_x_end,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_y_end,
    input  logic [lr2fb_pkg::GRAY_W-1:0]         i_gray,
    output logic                                 o_result_strobe,
    output logic [lr2fb_pkg::GRAY_W-1:0]         o_read_gray,
    output logic [lr2fb_pkg::STEP_W-1:0]         o_steps_taken
);

    // front -> queue
    logic            push;
    lr2fb_pkg::t_cmd push_cmd;
    logic            q_full;
    // queue -> back
    logic            pop;
    logic            q_empty;
    lr2fb_pkg::t_cmd head_cmd;
    // back status: reset clearing pass running
    logic            init_busy;
    // frame RAM ports
    logic                          ram_we;
    logic [lr2fb_pkg::FB_AW-1:0]   ram_waddr;
    logic [7:0]                    ram_wdata;
    logic                          ram_re;
    logic [lr2fb_pkg::FB_AW-1:0]   ram_raddr;
    logic [7:0]                    ram_rdata;

    // Front: accepts transactions and precomputes |dx|, |dy| and directions.
    lr2fb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_gray      (i_gray),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Decoupling queue between the two halves.
    lr2fb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head_cmd)
    );

    // Back: runs one command at a time against the frame RAM.
    lr2fb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (head_cmd),
        .o_pop         (pop),
        .o_init_busy   (init_busy),
        .o_ram_we      (ram_we),
        .o_ram_waddr   (ram_waddr),
        .o_ram_wdata   (ram_wdata),
        .o_ram_re      (ram_re),
        .o_ram_raddr   (ram_raddr),
        .i_ram_rdata   (ram_rdata),
        .o_strobe      (o_result_strobe),
        .o_read_gray   (o_read_gray),
        .o_steps_taken (o_steps_taken)
    );

    // Packed frame store, one byte = four pixels.
    lr2fb_ram #(
        .WIDTH (8),
        .DEPTH (lr2fb_pkg::FB_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

FILE: sv/lr2fb_ram.sv
// Generic simple dual-port RAM with registered read.
module lr2fb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/lr2fb_front.sv
// Front end: takes commands, works out line deltas and directions.
module lr2fb_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lr2fb_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_x_start,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_y_start,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_x_end,
    input  logic signed [lr2fb_pkg::COORD_W-1:0] i_y_end,
    input  logic [lr2fb_pkg::GRAY_W-1:0]        i_gray,
    input  logic                                i_init_busy,
    input  logic                                i_q_full,
    output logic                                o_push,
    output lr2fb_pkg::t_cmd                     o_cmd
);

    logic            r_valid;
    lr2fb_pkg::t_cmd r_cmd;
    lr2fb_pkg::t_cmd n_cmd;
    logic            accept;
    logic signed [lr2fb_pkg::COORD_W:0] diff_x;
    logic signed [lr2fb_pkg::COORD_W:0] diff_y;

    assign busy   = i_init_busy || (r_valid && i_q_full);
    assign accept = start && !busy;
    assign o_push = r_valid && !i_q_full;
    assign o_cmd  = r_cmd;

    always_comb begin
        diff_x = (lr2fb_pkg::COORD_W+1)'(i_x_end) - (lr2fb_pkg::COORD_W+1)'(i_x_start);
        diff_y = (lr2fb_pkg::COORD_W+1)'(i_y_end) - (lr2fb_pkg::COORD_W+1)'(i_y_start);
        n_cmd.x0     = i_x_start;
        n_cmd.y0     = i_y_start;
        n_cmd.x1     = i_x_end;
        n_cmd.y1     = i_y_end;
        n_cmd.gray   = i_gray;
        n_cmd.dx     = diff_x[lr2fb_pkg::COORD_W]
                       ? lr2fb_pkg::DELTA_W'(-diff_x) : lr2fb_pkg::DELTA_W'(diff_x);
        n_cmd.dy     = diff_y[lr2fb_pkg::COORD_W]
                       ? lr2fb_pkg::DELTA_W'(-diff_y) : lr2fb_pkg::DELTA_W'(diff_y);
        n_cmd.sx_neg = !(i_x_start < i_x_end);
        n_cmd.sy_neg = !(i_y_start < i_y_end);
        unique case (i_mode)
            lr2fb_pkg::MODE_LINE:  n_cmd.op = lr2fb_pkg::OP_LINE;
            lr2fb_pkg::MODE_READ:  n_cmd.op = lr2fb_pkg::OP_READ;
            lr2fb_pkg::MODE_CLEAR: n_cmd.op = lr2fb_pkg::OP_CLEAR;
            default:               n_cmd.op = lr2fb_pkg::OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

FILE: sv/lr2fb_queue.sv
// Two-entry command queue between front and back end.
`include "assert_macros.svh"

module lr2fb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lr2fb_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output lr2fb_pkg::t_cmd o_head
);

    lr2fb_pkg::t_cmd          r_mem [lr2fb_pkg::Q_DEPTH];
    logic [lr2fb_pkg::Q_AW-1:0] r_wr_ptr;
    logic [lr2fb_pkg::Q_AW-1:0] r_rd_ptr;
    logic [lr2fb_pkg::Q_AW:0]   r_count;

    assign o_full  = (r_count == (lr2fb_pkg::Q_AW+1)'(lr2fb_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `LR_ASSERT_NEVER(a_no_push_full, i_clk, i_rst_n, i_push && o_full && !i_pop)
    `LR_ASSERT_NEVER(a_no_pop_empty, i_clk, i_rst_n, i_pop && o_empty)

endmodule

FILE: sv/lr2fb_back.sv
// Back end: line stepping, pixel read and buffer clear on the frame RAM.
`include "assert_macros.svh"

module lr2fb_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  lr2fb_pkg::t_cmd                   i_head,
    output logic                              o_pop,
    output logic                              o_init_busy,
    output logic                              o_ram_we,
    output logic [lr2fb_pkg::FB_AW-1:0]       o_ram_waddr,
    output logic [7:0]                        o_ram_wdata,
    output logic                              o_ram_re,
    output logic [lr2fb_pkg::FB_AW-1:0]       o_ram_raddr,
    input  logic [7:0]                        i_ram_rdata,
    output logic                              o_strobe,
    output logic [lr2fb_pkg::GRAY_W-1:0]      o_read_gray,
    output logic [lr2fb_pkg::STEP_W-1:0]      o_steps_taken
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_CLR
    } t_state;

    localparam int CW = lr2fb_pkg::COORD_W;

    t_state                            r_state;
    lr2fb_pkg::t_cmd                   r_cmd;
    logic signed [CW-1:0]              r_x;
    logic signed [CW-1:0]              r_y;
    logic signed [lr2fb_pkg::ERR_W-1:0] r_err;
    logic [lr2fb_pkg::STEP_W-1:0]      r_count;
    logic [lr2fb_pkg::FB_AW-1:0]       r_baddr;
    logic [1:0]                        r_lane;
    logic                              r_on;
    logic [lr2fb_pkg::FB_AW-1:0]       r_clr_addr;
    logic [7:0]                        r_fill;
    logic                              r_init;
    logic                              r_strobe;
    logic [lr2fb_pkg::GRAY_W-1:0]      r_read_gray;
    logic [lr2fb_pkg::STEP_W-1:0]      r_steps;

    logic                              x_on;
    logic                              y_on;
    logic [lr2fb_pkg::PIX_W-1:0]       pix;
    logic [2:0]                        sh;
    logic [1:0]                        rd_px;
    logic [7:0]                        merged;
    logic signed [lr2fb_pkg::ERR_W:0]  e2;
    logic signed [lr2fb_pkg::ERR_W:0]  dx_w;
    logic signed [lr2fb_pkg::ERR_W:0]  mdy_w;
    logic                              step_x;
    logic                              step_y;
    logic signed [lr2fb_pkg::ERR_W-1:0] n_err;
    logic [lr2fb_pkg::STEP_W-1:0]      n_count;
    logic                              line_done;
    logic signed [lr2fb_pkg::ERR_W-1:0] err0;

    always_comb begin
        x_on = !r_x[CW-1] && (r_x[CW-2:0] < (CW-1)'(lr2fb_pkg::CANVAS_WIDTH));
        y_on = !r_y[CW-1] && (r_y[CW-2:0] < (CW-1)'(lr2fb_pkg::CANVAS_HEIGHT));
        pix  = lr2fb_pkg::PIX_W'(32'(r_y[CW-2:0]) * lr2fb_pkg::CANVAS_WIDTH
                                 + 32'(r_x[CW-2:0]));
        // first pixel of a byte sits in bits 7:6
        sh     = {~r_lane, 1'b0};
        rd_px  = 2'(i_ram_rdata >> sh);
        merged = (i_ram_rdata & ~(8'h03 << sh)) | (8'(r_cmd.gray) << sh);

        e2     = {r_err, 1'b0};
        dx_w   = $signed({4'b0, r_cmd.dx});
        mdy_w  = -$signed({4'b0, r_cmd.dy});
        step_x = (e2 >= mdy_w);
        step_y = (e2 <= dx_w);
        n_err  = r_err + (step_x ? lr2fb_pkg::ERR_W'(mdy_w) : '0)
                       + (step_y ? lr2fb_pkg::ERR_W'(dx_w) : '0);
        n_count   = r_count + 1'b1;
        line_done = ((r_x == r_cmd.x1) && (r_y == r_cmd.y1))
                    || (n_count >= lr2fb_pkg::MAX_STEPS);
        err0 = $signed({3'b0, i_head.dx}) - $signed({3'b0, i_head.dy});

        o_pop       = (r_state == S_IDLE) && !i_q_empty;
        o_ram_re    = (r_state == S_RD);
        o_ram_raddr = pix[lr2fb_pkg::PIX_W-1:2];
        o_ram_we    = (r_state == S_CLR)
                      || ((r_state == S_WR) && (r_cmd.op == lr2fb_pkg::OP_LINE) && r_on);
        o_ram_waddr = (r_state == S_CLR) ? r_clr_addr : r_baddr;
        o_ram_wdata = (r_state == S_CLR) ? r_fill : merged;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_init     <= 1'b1;
            r_clr_addr <= '0;
            r_fill     <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd   <= i_head;
                        r_x     <= i_head.x0;
                        r_y     <= i_head.y0;
                        r_err   <= err0;
                        r_count <= '0;
                        case (i_head.op) inside
                            lr2fb_pkg::OP_LINE, lr2fb_pkg::OP_READ: begin
                                r_state <= S_RD;
                            end
                            lr2fb_pkg::OP_CLEAR: begin
                                r_fill     <= {4{i_head.gray}};
                                r_clr_addr <= '0;
                                r_state    <= S_CLR;
                            end
                            default: begin
                                r_strobe    <= 1'b1;
                                r_read_gray <= '0;
                                r_steps     <= '0;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_baddr <= pix[lr2fb_pkg::PIX_W-1:2];
                    r_lane  <= pix[1:0];
                    r_on    <= x_on && y_on;
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_cmd.op == lr2fb_pkg::OP_READ) begin
                        r_strobe    <= 1'b1;
                        r_read_gray <= r_on ? rd_px : lr2fb_pkg::OFF_CANVAS_GRAY;
                        r_steps     <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_count <= n_count;
                        if (line_done) begin
                            r_strobe    <= 1'b1;
                            r_read_gray <= '0;
                            r_steps     <= n_count;
                            r_state     <= S_IDLE;
                        end else begin
                            r_err   <= n_err;
                            if (step_x) begin
                                r_x <= r_x + (r_cmd.sx_neg ? {CW{1'b1}} : CW'(1));
                            end
                            if (step_y) begin
                                r_y <= r_y + (r_cmd.sy_neg ? {CW{1'b1}} : CW'(1));
                            end
                            r_state <= S_RD;
                        end
                    end
                end
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == lr2fb_pkg::FB_AW'(lr2fb_pkg::FB_BYTES - 1)) begin
                        if (!r_init) begin
                            r_strobe    <= 1'b1;
                            r_read_gray <= '0;
                            r_steps     <= '0;
                        end
                        r_init  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_init_busy   = r_init;
    assign o_strobe      = r_strobe;
    assign o_read_gray   = r_read_gray;
    assign o_steps_taken = r_steps;

    `LR_ASSERT(a_strobe_in_idle, i_clk, i_rst_n, r_strobe |-> (r_state == S_IDLE))
    `LR_ASSERT_NEVER(a_no_result_in_init, i_clk, i_rst_n, r_init && r_strobe)
    `LR_ASSERT(a_count_bound, i_clk, i_rst_n, (r_state == S_WR) |-> (r_count < lr2fb_pkg::MAX_STEPS))

endmodule
